@@ hw/rtl/rrast_pkg.sv @@
// ----------------------------------------------------------------------------
// rrast_pkg
// Shared types and codes of the rectangle rasterizer: command and response
// payloads, the scan job handed to the pixel sequencer, and default sizes.
// ----------------------------------------------------------------------------
package rrast_pkg;

	localparam int MAX_SIDE_DEF  = 512;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_DRAW  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
	localparam logic [1:0] ST_OUTSIDE   = 2'd2;

	localparam logic [1:0] CFG_CANVAS_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_CANVAS_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_BACKGROUND_CHAR = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic               rect_filled;
		logic signed [23:0] rect_left;
		logic signed [23:0] rect_top;
		logic [22:0]        rect_width;
		logic [22:0]        rect_height;
		logic [7:0]         paint_char;
		logic [8:0]         read_row;
		logic [8:0]         read_col;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] pixel_char;
	} rsp_t;

	typedef struct packed {
		logic               is_clear;
		logic               rect_filled;
		logic signed [23:0] rect_left;
		logic signed [23:0] rect_top;
		logic [22:0]        rect_width;
		logic [22:0]        rect_height;
		logic [7:0]         paint_char;
	} scan_job_t;

endpackage

@@ hw/rtl/rrast_mem.sv @@
// ----------------------------------------------------------------------------
// rrast_mem
// Canvas storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrast_mem #(
	parameter  int DEPTH  = 4,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/rrast_scan.sv @@
// ----------------------------------------------------------------------------
// rrast_scan
// Pixel sequencer: walks every canvas pixel in use, one per cycle, and issues
// a canvas write where a clear covers it or, for a draw, the filled rectangle
// or its outline does. Edge distances are kept as running sums in fixed point.
// ----------------------------------------------------------------------------
module rrast_scan import rrast_pkg::*; #(
	parameter  int MAX_SIDE  = MAX_SIDE_DEF,
	parameter  int FRAC_BITS = FRAC_BITS_DEF,
	localparam int CNT_W     = $clog2(MAX_SIDE + 1),
	localparam int ADDR_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  scan_job_t         job,
	input  logic [CNT_W-1:0]  used_w,
	input  logic [CNT_W-1:0]  used_h,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [7:0]        wr_data,
	output logic              done
);

	localparam int DW = (((CNT_W + FRAC_BITS) > 25) ? (CNT_W + FRAC_BITS) : 25) + 2;
	localparam logic signed [DW-1:0] ONE = DW'(64'd1 << FRAC_BITS);

	logic                     busy_q;
	logic                     done_q;
	scan_job_t                job_q;
	logic [CNT_W-1:0]         row_q;
	logic [CNT_W-1:0]         col_q;
	logic [CNT_W-1:0]         w_q;
	logic [CNT_W-1:0]         h_q;
	logic [ADDR_W-1:0]        base_q;
	logic signed [DW-1:0]     dt_q;
	logic signed [DW-1:0]     db_q;
	logic signed [DW-1:0]     dl_q;
	logic signed [DW-1:0]     dr_q;
	logic signed [DW-1:0]     dt0;
	logic signed [DW-1:0]     db0;
	logic signed [DW-1:0]     dl0;
	logic signed [DW-1:0]     dr0;
	logic signed [DW-1:0]     dl_row;
	logic signed [DW-1:0]     dr_row;
	logic                     col_last;
	logic                     row_last;
	logic                     in_rect;
	logic                     near_edge;
	logic                     nonempty;

	always_comb begin
		dt0    = -DW'(job.rect_top);
		db0    = DW'(job.rect_top) + $signed({{(DW-23){1'b0}}, job.rect_height});
		dl0    = -DW'(job.rect_left);
		dr0    = DW'(job.rect_left) + $signed({{(DW-23){1'b0}}, job.rect_width});
		dl_row = -DW'(job_q.rect_left);
		dr_row = DW'(job_q.rect_left) + $signed({{(DW-23){1'b0}}, job_q.rect_width});
		col_last  = (col_q + CNT_W'(1)) == w_q;
		row_last  = (row_q + CNT_W'(1)) == h_q;
		in_rect   = !dl_q[DW-1] && !dr_q[DW-1] && !dt_q[DW-1] && !db_q[DW-1];
		near_edge = (dl_q < ONE) || (dr_q < ONE) || (dt_q < ONE) || (db_q < ONE);
		nonempty  = (used_w != '0) && (used_h != '0);
	end

	assign wr_en   = busy_q && (job_q.is_clear || (in_rect && (job_q.rect_filled || near_edge)));
	assign wr_addr = base_q + ADDR_W'(col_q);
	assign wr_data = job_q.paint_char;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= nonempty;
				done_q <= !nonempty;
			end else if (busy_q && col_last && row_last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q  <= job;
			w_q    <= used_w;
			h_q    <= used_h;
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
			dt_q   <= dt0;
			db_q   <= db0;
			dl_q   <= dl0;
			dr_q   <= dr0;
		end else if (busy_q) begin
			if (col_last) begin
				col_q  <= '0;
				dl_q   <= dl_row;
				dr_q   <= dr_row;
				row_q  <= row_q + CNT_W'(1);
				base_q <= base_q + ADDR_W'(MAX_SIDE);
				dt_q   <= dt_q + ONE;
				db_q   <= db_q - ONE;
			end else begin
				col_q <= col_q + CNT_W'(1);
				dl_q  <= dl_q + ONE;
				dr_q  <= dr_q - ONE;
			end
		end
	end

endmodule

@@ hw/rtl/rectangle_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// rectangle_rasterizer_core
// Character canvas with clear, filled/outline rectangle draw and pixel read.
// ----------------------------------------------------------------------------
// One command is in flight at a time. Clear and draw walk every pixel in use,
// one pixel per cycle through the single canvas write port. A read goes
// through the registered read port. Rejected draws, reads off the canvas and
// the unused command go straight to the response. The response register frees
// the command side once a result is loaded into it, which waits while an
// earlier response is held and not taken. The canvas holds no defined contents
// after reset: issue a clear before reading pixels that no draw has covered.
// ----------------------------------------------------------------------------
module rectangle_rasterizer_core import rrast_pkg::*; #(
	parameter int MAX_SIDE  = MAX_SIDE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	localparam int CNT_W  = $clog2(MAX_SIDE + 1);
	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RDATA,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [9:0]        width_q;
	logic [9:0]        height_q;
	logic [7:0]        bg_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic              rsp_load;
	logic [1:0]        acc_status;
	logic [CNT_W-1:0]  used_w;
	logic [CNT_W-1:0]  used_h;
	logic              accept;
	logic              rd_outside;
	logic              zero_size;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              scan_start;
	scan_job_t         job;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              scan_done;

	assign cfg_ready = 1'b1;
	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign accept    = cmd_valid && cmd_ready;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		used_w = (32'(width_q) > MAX_SIDE) ? CNT_W'(MAX_SIDE) : CNT_W'(width_q);
		used_h = (32'(height_q) > MAX_SIDE) ? CNT_W'(MAX_SIDE) : CNT_W'(height_q);
		rd_outside = (32'(cmd.read_row) >= 32'(used_h)) ||
		             (32'(cmd.read_col) >= 32'(used_w));
		zero_size  = (cmd.rect_width == '0) || (cmd.rect_height == '0);
		if ((cmd.command == CMD_DRAW) && zero_size) begin
			acc_status = ST_ZERO_SIZE;
		end else if ((cmd.command == CMD_READ) && rd_outside) begin
			acc_status = ST_OUTSIDE;
		end else begin
			acc_status = ST_OK;
		end
		rd_en      = accept && (cmd.command == CMD_READ) && !rd_outside;
		rd_addr    = ADDR_W'(32'(cmd.read_row) * MAX_SIDE + 32'(cmd.read_col));
		scan_start = accept && ((cmd.command == CMD_CLEAR) ||
		             ((cmd.command == CMD_DRAW) && !zero_size));
		job.is_clear    = (cmd.command == CMD_CLEAR);
		job.rect_filled = cmd.rect_filled;
		job.rect_left   = cmd.rect_left;
		job.rect_top    = cmd.rect_top;
		job.rect_width  = cmd.rect_width;
		job.rect_height = cmd.rect_height;
		job.paint_char  = (cmd.command == CMD_CLEAR) ? bg_q : cmd.paint_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd1;
			height_q <= 10'd1;
			bg_q     <= 8'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CANVAS_WIDTH:    width_q  <= cfg_data;
				CFG_CANVAS_HEIGHT:   height_q <= cfg_data;
				CFG_BACKGROUND_CHAR: bg_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '{status: acc_status, pixel_char: 8'd0};
						case (cmd.command)
							CMD_CLEAR: state_q <= S_SCAN;
							CMD_DRAW: begin
								if (zero_size) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_READ: begin
								if (rd_outside) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_RDATA;
								end
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_RESP;
					end
				end
				S_RDATA: begin
					res_q.pixel_char <= rd_data;
					state_q          <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	rrast_scan #(
		.MAX_SIDE  (MAX_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.job     (job),
		.used_w  (used_w),
		.used_h  (used_h),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.done    (scan_done)
	);

	rrast_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

@@ tb/sv/rectangle_rasterizer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_rasterizer_core_test
// Self-checking bench for the rectangle rasterizer. A scoreboard keeps its own
// copy of the canvas and the size/background registers, predicts the response
// of every accepted command, and compares each response field by field. The
// bench runs directed corner cases, then phases of random commands over a
// range of canvas sizes, with random idle bursts on both handshakes.
// ----------------------------------------------------------------------------
module rectangle_rasterizer_core_test;
	import rrast_pkg::*;

	localparam int UNIT            = 1 << FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 8;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	class canvas_tracker;
		bit [7:0] pixels [MAX_SIDE_DEF * MAX_SIDE_DEF];
		int       width_reg;
		int       height_reg;
		bit [7:0] background;
		rsp_t     pending [$];
		int       errors;

		function new();
			width_reg  = 1;
			height_reg = 1;
			background = 8'd32;
			errors     = 0;
		endfunction

		function int used_cols();
			return width_reg > MAX_SIDE_DEF ? MAX_SIDE_DEF : width_reg;
		endfunction

		function int used_rows();
			return height_reg > MAX_SIDE_DEF ? MAX_SIDE_DEF : height_reg;
		endfunction

		function void note_register(logic [1:0] index, logic [9:0] data);
			case (index)
				CFG_CANVAS_WIDTH:    width_reg = data;
				CFG_CANVAS_HEIGHT:   height_reg = data;
				CFG_BACKGROUND_CHAR: background = data[7:0];
				default: ;
			endcase
		endfunction

		function void note_command(cmd_t c);
			rsp_t   want;
			int     rows;
			int     cols;
			longint left;
			longint top;
			longint wd;
			longint ht;
			longint d_top;
			longint d_bot;
			longint d_left;
			longint d_right;
			bit     edge_hit;
			want = '0;
			want.status = ST_OK;
			rows = used_rows();
			cols = used_cols();
			case (c.command)
				CMD_CLEAR: begin
					for (int r = 0; r < rows; r++)
						for (int k = 0; k < cols; k++)
							pixels[r * MAX_SIDE_DEF + k] = background;
				end
				CMD_DRAW: begin
					if (c.rect_width == '0 || c.rect_height == '0)
						want.status = ST_ZERO_SIZE;
					else begin
						left = longint'($signed(c.rect_left));
						top  = longint'($signed(c.rect_top));
						wd   = longint'(c.rect_width);
						ht   = longint'(c.rect_height);
						for (int r = 0; r < rows; r++) begin
							d_top = longint'(r) * UNIT - top;
							d_bot = top + ht - longint'(r) * UNIT;
							if (d_top < 0 || d_bot < 0)
								continue;
							for (int k = 0; k < cols; k++) begin
								d_left  = longint'(k) * UNIT - left;
								d_right = left + wd - longint'(k) * UNIT;
								if (d_left < 0 || d_right < 0)
									continue;
								edge_hit = d_left < UNIT || d_right < UNIT ||
									d_top < UNIT || d_bot < UNIT;
								if (c.rect_filled || edge_hit)
									pixels[r * MAX_SIDE_DEF + k] = c.paint_char;
							end
						end
					end
				end
				CMD_READ: begin
					if (c.read_row >= rows || c.read_col >= cols)
						want.status = ST_OUTSIDE;
					else
						want.pixel_char = pixels[c.read_row * MAX_SIDE_DEF + c.read_col];
				end
				default: ;
			endcase
			pending.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$display("%0t: response with none expected, status %0d pixel_char %0d",
					$time, got.status, got.pixel_char);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.pixel_char !== want.pixel_char) begin
				$display("%0t: pixel_char mismatch, expected 0x%02h, actual 0x%02h",
					$time, want.pixel_char, got.pixel_char);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	cmd_t       cmd = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	canvas_tracker track;
	int            cmd_gap_pct = 20;
	int            rsp_gap_pct = 20;
	bit            hold_off_request = 1'b0;

	rectangle_rasterizer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic cmd_t make_draw(bit filled, int left, int top, int wd, int ht,
		logic [7:0] ch);
		cmd_t c;
		c = '0;
		c.command     = CMD_DRAW;
		c.rect_filled = filled;
		c.rect_left   = 24'(left);
		c.rect_top    = 24'(top);
		c.rect_width  = 23'(wd);
		c.rect_height = 23'(ht);
		c.paint_char  = ch;
		return c;
	endfunction

	function automatic cmd_t make_read(int row, int col);
		cmd_t c;
		c = '0;
		c.command  = CMD_READ;
		c.read_row = 9'(row);
		c.read_col = 9'(col);
		return c;
	endfunction

	function automatic cmd_t make_plain(logic [1:0] command);
		cmd_t c;
		c = '0;
		c.command = command;
		return c;
	endfunction

	// edges mostly within a few units of the canvas, fraction bits random
	function automatic logic signed [23:0] random_origin(int span);
		int v;
		v = $urandom_range(0, (span + 6) * UNIT);
		return 24'(v - 3 * UNIT);
	endfunction

	function automatic logic [22:0] random_extent(int span);
		int pick;
		pick = $urandom_range(0, 11);
		if (pick == 0)
			return '0;
		if (pick < 3)
			return 23'($urandom_range(1, 2 * UNIT));
		return 23'($urandom_range(1, (span + 4) * UNIT));
	endfunction

	function automatic cmd_t random_command();
		cmd_t      c;
		bit [127:0] noise;
		int        cols;
		int        rows;
		int        pick;
		noise = {$urandom, $urandom, $urandom, $urandom};
		c = noise[$bits(cmd_t)-1:0];
		cols = track.used_cols();
		rows = track.used_rows();
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return c;
		if (pick < 12)
			c.command = (pick < 11) ? CMD_CLEAR : CMD_UNUSED;
		else if (pick < 60) begin
			c.command     = CMD_DRAW;
			c.rect_left   = random_origin(cols);
			c.rect_top    = random_origin(rows);
			c.rect_width  = random_extent(cols);
			c.rect_height = random_extent(rows);
		end else begin
			c.command = CMD_READ;
			if ($urandom_range(0, 4) != 0 && rows != 0 && cols != 0) begin
				c.read_row = 9'($urandom_range(0, rows - 1));
				c.read_col = 9'($urandom_range(0, cols - 1));
			end
		end
		return c;
	endfunction

	task automatic send_command(input cmd_t c);
		if (cmd_gap_pct != 0 && $urandom_range(0, 99) < cmd_gap_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		track.note_command(c);
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (track.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_canvas(input logic [9:0] cols_value, input logic [9:0] rows_value,
		input logic [7:0] bg);
		logic [1:0] idx [4];
		logic [9:0] val [4];
		idx = '{CFG_UNUSED, CFG_CANVAS_WIDTH, CFG_CANVAS_HEIGHT, CFG_BACKGROUND_CHAR};
		val = '{10'($urandom), cols_value, rows_value, {2'($urandom), bg}};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			track.note_register(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// every phase opens with a clear so that no read hits an unwritten pixel
	task automatic run_phase(input int cols, input int rows, input logic [7:0] bg,
		input int items, input int cmd_pct, input int rsp_pct, input bit hold);
		cmd_t c;
		configure_canvas(10'(cols), 10'(rows), bg);
		cmd_gap_pct = cmd_pct;
		rsp_gap_pct = rsp_pct;
		c = random_command();
		c.command = CMD_CLEAR;
		send_command(c);
		if (hold)
			hold_off_request = 1'b1;
		repeat (items) send_command(random_command());
		settle();
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				track.check_response(rsp);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && rsp_gap_pct != 0 &&
				$urandom_range(0, 99) < rsp_gap_pct)
				stall_left = $urandom_range(1, 16);
			if (stall_left != 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else
				rsp_ready <= 1'b1;
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
				(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		track = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: 1x1 canvas
		send_command(make_read(1, 0));
		send_command(make_read(0, 1));
		send_command(make_plain(CMD_CLEAR));
		send_command(make_read(0, 0));
		send_command(make_plain(CMD_UNUSED));
		settle();

		configure_canvas(10'd16, 10'd12, 8'h2E);
		send_command(make_plain(CMD_CLEAR));
		send_command(make_draw(1'b1, 2 * UNIT, UNIT, 5 * UNIT, 3 * UNIT, 8'h23));
		send_command(make_draw(1'b0, UNIT + UNIT / 2, UNIT + UNIT / 2,
			8 * UNIT + UNIT / 4, 6 * UNIT + UNIT / 2, 8'h6F));
		send_command(make_draw(1'b1, 0, 0, 0, 4 * UNIT, 8'h21));
		send_command(make_draw(1'b1, 0, 0, 4 * UNIT, 0, 8'h21));
		send_command(make_draw(1'b1, -8388608, -8388608, 8388607, 8388607, 8'hFF));
		send_command(make_draw(1'b0, 8388607, 8388607, 1, 1, 8'h00));
		send_command(make_draw(1'b0, 0, 0, 8388607, 8388607, 8'h00));
		// half-unit wide outline: a single column
		send_command(make_draw(1'b0, 3 * UNIT, 5 * UNIT, UNIT / 2, 4 * UNIT, 8'h7C));
		send_command(make_read(1, 2));
		send_command(make_read(4, 7));
		send_command(make_read(0, 0));
		send_command(make_read(11, 15));
		send_command(make_read(5, 5));
		send_command(make_read(2, 4));
		send_command(make_read(6, 3));
		send_command(make_read(3, 9));
		send_command(make_read(511, 511));
		send_command(make_read(12, 0));
		send_command(make_read(0, 16));
		settle();

		run_phase(0, 5, 8'h41, 4, 20, 20, 1'b0);
		run_phase(1023, 3, 8'hFF, 5, 20, 20, 1'b0);
		run_phase(2, 600, 8'h00, 5, 20, 20, 1'b0);
		run_phase(512, 2, 8'h5A, 4, 0, 0, 1'b0);
		run_phase($urandom_range(1, 24), $urandom_range(1, 24), 8'($urandom), 8, 30, 30, 1'b0);
		run_phase($urandom_range(1, 24), $urandom_range(1, 24), 8'($urandom), 7, 0, 0, 1'b0);
		run_phase(4, 3, 8'($urandom), 8, 0, 20, 1'b1);
		run_phase($urandom_range(1, 24), $urandom_range(1, 24), 8'($urandom), 8, 50, 10, 1'b0);
		run_phase($urandom_range(1, 24), $urandom_range(1, 24), 8'($urandom), 8, 10, 50, 1'b0);
		run_phase($urandom_range(1, 24), $urandom_range(1, 24), 8'($urandom), 7, 0, 0, 1'b0);

		if (track.errors == 0 && track.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
